/* rtl/ewcc_pkg.sv */
// shared types and constants for the ecn window congestion control block
`timescale 1ns / 1ps
package ewcc_pkg;

    localparam int unsigned RESULT_CAP  = 32;
    localparam int unsigned MSS_W       = 16;
    localparam int unsigned WIN_W       = 32;
    localparam int unsigned SEQ_W       = 48;
    localparam int unsigned DIVIDEND_W  = 36;
    localparam int unsigned ADDR_W      = 3;
    localparam int unsigned DATA_W      = 32;

    localparam logic REG_SEGMENT_BYTES     = 1'b0;
    localparam logic REG_INIT_WINDOW_BYTES = 1'b1;

    localparam logic [MSS_W-1:0] MSS_RESET      = 16'd1500;
    localparam logic [WIN_W-1:0] INIT_WIN_RESET = 32'd15000;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_ACK    = 2'd1,
        CMD_NACK   = 2'd2,
        CMD_IGNORE = 2'd3
    } t_command;

    typedef struct packed {
        t_command          command;
        logic [SEQ_W-1:0]  ack_number;
        logic              ecn_marked;
    } t_in_item;

    typedef struct packed {
        logic [SEQ_W-1:0]  packet_sequence;
        logic              last_of_burst;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_DIV_START,
        ST_DIV,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic latch;
        logic start;
        logic release_seg;
        logic backoff;
        logic grow_small;
        logic mul;
        logic div_start;
        logic grow_div;
        logic clear_count;
        logic send;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic     running;
        t_command command;
        logic     marked;
        logic     small_window;
        logic     div_done;
        logic     send_ok;
        logic     pend_valid;
        logic     out_free;
    } t_dp_status;

endpackage

/* rtl/ewcc_regs.sv */
// apb configuration registers: segment size and initial window
`timescale 1ns / 1ps
module ewcc_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ewcc_pkg::ADDR_W-1:0] paddr,
    input  logic [ewcc_pkg::DATA_W-1:0] pwdata,
    output logic [ewcc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output logic [ewcc_pkg::MSS_W-1:0]  o_mss,
    output logic [ewcc_pkg::WIN_W-1:0]  o_init_window
);
    import ewcc_pkg::*;

    logic [MSS_W-1:0] r_mss;
    logic [WIN_W-1:0] r_init_window;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mss         <= MSS_RESET;
            r_init_window <= INIT_WIN_RESET;
        end else if (wr_en) begin
            if (paddr[2] == REG_SEGMENT_BYTES) begin
                r_mss <= pwdata[MSS_W-1:0];
            end else begin
                r_init_window <= pwdata[WIN_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_SEGMENT_BYTES) begin
            prdata = {{(DATA_W-MSS_W){1'b0}}, r_mss};
        end else begin
            prdata = r_init_window;
        end
    end

    assign o_mss         = r_mss;
    assign o_init_window = r_init_window;

endmodule

/* rtl/ewcc_divider.sv */
// radix-2 restoring divider for the window growth term
`timescale 1ns / 1ps
module ewcc_divider (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ewcc_pkg::DIVIDEND_W-1:0] i_dividend,
    input  logic [ewcc_pkg::WIN_W-1:0]      i_divisor,
    output logic [ewcc_pkg::DIVIDEND_W-1:0] o_quotient,
    output logic                            o_done
);
    import ewcc_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [WIN_W-1:0]      r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [WIN_W-1:0]      r_divisor;
    logic [WIN_W:0]        trial;
    logic                  ge;
    logic [WIN_W:0]        diff;

    assign trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign ge    = trial >= {1'b0, r_divisor};
    assign diff  = trial - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quo     <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

/* rtl/ewcc_datapath.sv */
// window, in-flight and sequence state, growth divider and send output stage
`timescale 1ns / 1ps
module ewcc_datapath #(
    parameter int unsigned MAX_BURST = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ewcc_pkg::t_dp_cmd          i_cmd,
    output ewcc_pkg::t_dp_status       o_status,
    input  ewcc_pkg::t_in_item         i_in_item,
    input  logic [ewcc_pkg::MSS_W-1:0] i_mss,
    input  logic [ewcc_pkg::WIN_W-1:0] i_init_window,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output ewcc_pkg::t_out_item        o_out_item
);
    import ewcc_pkg::*;

    localparam int unsigned LIMIT = (MAX_BURST < RESULT_CAP) ? MAX_BURST : RESULT_CAP;
    localparam int unsigned CNT_W = $clog2(LIMIT + 1);
    localparam int unsigned GROW_W = MSS_W + 4;

    logic [WIN_W-1:0]      r_window;
    logic [WIN_W-1:0]      r_in_flight;
    logic [SEQ_W-1:0]      r_highest;
    logic [SEQ_W-1:0]      r_decision;
    logic                  r_running;
    t_command              r_cmd;
    logic [SEQ_W-1:0]      r_number;
    logic                  r_marked;
    logic [WIN_W-1:0]      r_prod;
    logic [CNT_W-1:0]      r_count;
    logic                  r_pend_valid;
    logic [SEQ_W-1:0]      r_pend_seq;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic                  out_free;
    logic                  small_window;
    logic [WIN_W:0]        send_sum;
    logic                  send_ok;
    logic [WIN_W-1:0]      half_window;
    logic [WIN_W-1:0]      backoff_window;
    logic [GROW_W-1:0]     mss_x10;
    logic [GROW_W-1:0]     small_add;
    logic [WIN_W:0]        small_sum;
    logic [DIVIDEND_W:0]   div_sum;
    logic [WIN_W:0]        flight_sum;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVIDEND_W-1:0] quotient;
    logic                  div_done;

    ewcc_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (r_window),
        .o_quotient (quotient),
        .o_done     (div_done)
    );

    assign out_free     = !r_out_valid || !i_out_stall;
    assign small_window = (r_window < {{(WIN_W-MSS_W){1'b0}}, i_mss}) || (r_window == '0);
    assign send_sum     = {1'b0, r_in_flight} + {{(WIN_W-MSS_W+1){1'b0}}, i_mss};
    assign send_ok      = (r_count < CNT_W'(LIMIT)) && (send_sum < {1'b0, r_window});
    assign half_window  = {1'b0, r_window[WIN_W-1:1]};
    assign backoff_window = (half_window < {{(WIN_W-MSS_W){1'b0}}, i_mss})
                          ? {{(WIN_W-MSS_W){1'b0}}, i_mss} : half_window;
    assign mss_x10      = {1'b0, i_mss, 3'b000} + {3'b000, i_mss, 1'b0};
    assign small_add    = (r_window < {{(WIN_W-MSS_W){1'b0}}, i_mss}) ? mss_x10 : '0;
    assign small_sum    = {1'b0, r_window} + {{(WIN_W-GROW_W+1){1'b0}}, small_add};
    assign div_sum      = {{(DIVIDEND_W-WIN_W+1){1'b0}}, r_window} + {1'b0, quotient};
    assign flight_sum   = send_sum;
    assign dividend     = {1'b0, r_prod, 3'b000} + {3'b000, r_prod, 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd    <= i_in_item.command;
            r_number <= i_in_item.ack_number;
            r_marked <= i_in_item.ecn_marked;
        end
        if (i_cmd.mul) begin
            r_prod <= {{(WIN_W-MSS_W){1'b0}}, i_mss} * {{(WIN_W-MSS_W){1'b0}}, i_mss};
        end
        if (i_cmd.send) begin
            r_pend_seq <= r_highest + SEQ_W'(1);
        end
        if (i_cmd.send && r_pend_valid) begin
            r_out_item <= '{packet_sequence: r_pend_seq, last_of_burst: 1'b0};
        end else if (i_cmd.finish && r_pend_valid) begin
            r_out_item <= '{packet_sequence: r_pend_seq, last_of_burst: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window     <= '0;
            r_in_flight  <= '0;
            r_highest    <= '0;
            r_decision   <= '0;
            r_running    <= 1'b0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_running <= 1'b1;
                r_highest <= '0;
                r_window  <= i_init_window;
            end
            if (i_cmd.release_seg) begin
                if (r_in_flight > {{(WIN_W-MSS_W){1'b0}}, i_mss}) begin
                    r_in_flight <= r_in_flight - {{(WIN_W-MSS_W){1'b0}}, i_mss};
                end else begin
                    r_in_flight <= '0;
                end
            end
            if (i_cmd.backoff && (r_number >= r_decision)) begin
                r_window   <= backoff_window;
                r_decision <= r_highest + {{(SEQ_W-WIN_W){1'b0}}, backoff_window};
            end
            if (i_cmd.grow_small) begin
                r_window <= small_sum[WIN_W] ? '1 : small_sum[WIN_W-1:0];
            end
            if (i_cmd.grow_div) begin
                r_window <= (|div_sum[DIVIDEND_W:WIN_W]) ? '1 : div_sum[WIN_W-1:0];
            end
            if (i_cmd.clear_count) begin
                r_count <= '0;
            end
            if (i_cmd.send) begin
                r_highest    <= r_highest + {{(SEQ_W-MSS_W){1'b0}}, i_mss};
                r_in_flight  <= flight_sum[WIN_W] ? '1 : flight_sum[WIN_W-1:0];
                r_count      <= r_count + 1'b1;
                r_pend_valid <= 1'b1;
            end else if (i_cmd.finish) begin
                r_pend_valid <= 1'b0;
            end
            if ((i_cmd.send || i_cmd.finish) && r_pend_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status = '{
        running:      r_running,
        command:      r_cmd,
        marked:       r_marked,
        small_window: small_window,
        div_done:     div_done,
        send_ok:      send_ok,
        pend_valid:   r_pend_valid,
        out_free:     out_free
    };

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LIMIT))
        else $error("burst count beyond limit");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_cmd.send || i_cmd.finish) && r_pend_valid) |-> out_free)
        else $error("output stage overwritten while held");

    a_backoff_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.backoff && (r_number >= r_decision))
        |=> (r_window >= {{(WIN_W-MSS_W){1'b0}}, $past(i_mss)}))
        else $error("window below one segment after backoff");

endmodule

/* rtl/ewcc_ctrl.sv */
// controller state machine sequencing decode, growth divide and send burst
`timescale 1ns / 1ps
module ewcc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ewcc_pkg::t_dp_status i_status,
    output ewcc_pkg::t_dp_cmd    o_cmd
);
    import ewcc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                case (i_status.command)
                    CMD_START: n_state = ST_SEND;
                    CMD_ACK: begin
                        if (!i_status.running) begin
                            n_state = ST_IDLE;
                        end else if (i_status.marked || i_status.small_window) begin
                            n_state = ST_SEND;
                        end else begin
                            n_state = ST_MUL;
                        end
                    end
                    CMD_NACK: n_state = i_status.running ? ST_SEND : ST_IDLE;
                    default:  n_state = ST_IDLE;
                endcase
            end
            ST_MUL:       n_state = ST_DIV_START;
            ST_DIV_START: n_state = ST_DIV;
            ST_DIV: begin
                if (i_status.div_done) n_state = ST_SEND;
            end
            ST_SEND: begin
                if (!(i_status.pend_valid && !i_status.out_free) && !i_status.send_ok) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: o_cmd.latch = i_in_valid;
            ST_DECODE: begin
                case (i_status.command)
                    CMD_START: begin
                        o_cmd.start       = 1'b1;
                        o_cmd.clear_count = 1'b1;
                    end
                    CMD_ACK: begin
                        if (i_status.running) begin
                            o_cmd.release_seg = 1'b1;
                            o_cmd.clear_count = 1'b1;
                            if (i_status.marked) begin
                                o_cmd.backoff = 1'b1;
                            end else if (i_status.small_window) begin
                                o_cmd.grow_small = 1'b1;
                            end
                        end
                    end
                    CMD_NACK: begin
                        if (i_status.running) begin
                            o_cmd.release_seg = 1'b1;
                            o_cmd.backoff     = 1'b1;
                            o_cmd.clear_count = 1'b1;
                        end
                    end
                    default: o_cmd = '0;
                endcase
            end
            ST_MUL:       o_cmd.mul = 1'b1;
            ST_DIV_START: o_cmd.div_start = 1'b1;
            ST_DIV:       o_cmd.grow_div = i_status.div_done;
            ST_SEND: begin
                if (!(i_status.pend_valid && !i_status.out_free)) begin
                    o_cmd.send   = i_status.send_ok;
                    o_cmd.finish = !i_status.send_ok;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !i_status.pend_valid)
        else $error("segment left pending at end of burst");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside divide state");

    a_send_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEND) |-> i_status.running)
        else $error("sending while flow not running");

endmodule

/* rtl/ecn_window_congestion_control.sv */
// top level of the ecn-driven aimd congestion window controller
`timescale 1ns / 1ps
// One transaction is taken at a time. A start, a marked ack, a nack or a
// growing ack whose window is below one segment is decoded and then goes
// straight to the send burst: one segment per cycle unless the output is
// held, then the burst closes. An unmarked ack with a window of at least
// one segment first squares the segment size and runs the 36-step serial
// divider for the growth term before the first send, then sends the same way.
// Sends are paced by the output register: a held result stalls the burst.
// Ignored commands and items before start send nothing.
module ecn_window_congestion_control #(
    parameter int unsigned MAX_BURST = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ewcc_pkg::ADDR_W-1:0] paddr,
    input  logic [ewcc_pkg::DATA_W-1:0] pwdata,
    output logic [ewcc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  ewcc_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output ewcc_pkg::t_out_item         o_out_item
);
    import ewcc_pkg::*;

    logic [MSS_W-1:0] mss;
    logic [WIN_W-1:0] init_window;
    t_dp_cmd          dp_cmd;
    t_dp_status       dp_status;

    ewcc_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_mss         (mss),
        .o_init_window (init_window)
    );

    ewcc_datapath #(
        .MAX_BURST (MAX_BURST)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_in_item     (i_in_item),
        .i_mss         (mss),
        .i_init_window (init_window),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item)
    );

    ewcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

endmodule
